FILE: rtl/lu_pkg.sv
// lu_pkg: shared types, codes and constants of the lu linear solver
// depends on nothing; imported by the solver top level, its divider and its checker
package lu_pkg;

  localparam int LU_MAX_ORDER     = 8;
  localparam int LU_FRACTION_BITS = 16;

  // stream and register port widths
  localparam int LU_S_TDATA_W = 40;
  localparam int LU_S_TUSER_W = 2;
  localparam int LU_M_TDATA_W = 40;
  localparam int LU_M_TUSER_W = 3;
  localparam int LU_PADDR_W   = 3;

  // request commands
  localparam logic [1:0] CMD_MATRIX  = 2'd0;
  localparam logic [1:0] CMD_RHS     = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_SINGULAR = 2'd1;
  localparam logic [1:0] STAT_SAT      = 2'd2;

  // register indexes (paddr[2])
  localparam logic REG_SIZE = 1'b0;
  localparam logic REG_MODE = 1'b1;

  localparam logic [31:0] LU_SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] LU_SAT_MIN = 32'h8000_0000;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_CP_RD, ST_CP_WR,
    ST_LU_COL, ST_LU_ROW, ST_LU_LD, ST_LU_ST,
    ST_DOT_RD, ST_DOT_MUL, ST_DOT_RND, ST_DOT_ACC,
    ST_PIV_M1, ST_PIV_M2, ST_PIV_CMP,
    ST_SW_CHK, ST_SW_RD, ST_SW_W1, ST_SW_W2, ST_SW_SC,
    ST_PV_RD, ST_PV_FIX,
    ST_DV_RD, ST_DV_GO, ST_DV_WT,
    ST_SB_INIT, ST_FW_ROW, ST_FW_SW, ST_FW_ST,
    ST_BK_ROW, ST_BK_ST, ST_BK_GO, ST_BK_WT,
    ST_OUT_WR,
    ST_EM_RD, ST_EM_SHOW, ST_EM_WAIT
  } lu_state_t;

  typedef enum logic [1:0] {
    PH_LU,
    PH_FWD,
    PH_BACK
  } lu_phase_t;

  // magnitude of a 32-bit two's complement value
  function automatic logic [31:0] lu_mag(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

endpackage

FILE: rtl/lu_div.sv
// lu_div: restoring fixed-point divider, one quotient bit per cycle
// computes round((num << FRACTION_BITS) / den), saturated to 32 bits; uses lu_pkg
module lu_div import lu_pkg::*; #(
  parameter int FRACTION_BITS = LU_FRACTION_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo,
  output logic        sat
);

  localparam int NW   = 32 + FRACTION_BITS;
  localparam int CNTW = $clog2(NW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [NW-1:0]   nq;
  logic [31:0]     rem;
  logic [31:0]     d;
  logic            neg;

  logic [31:0] num_mag, den_mag, den_eff;
  logic        den_zero;
  logic [32:0] trial;
  logic        qbit;

  assign num_mag  = lu_mag(num);
  assign den_mag  = lu_mag(den);
  assign den_zero = (den_mag == 32'd0);
  assign den_eff  = den_zero ? 32'd1 : den_mag;
  assign trial    = {rem, nq[NW-1]};
  assign qbit     = (trial >= {1'b0, d});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NW);
        d    <= den_eff;
        neg  <= den_zero ? num[31] : (num[31] ^ den[31]);
        nq   <= {num_mag, {FRACTION_BITS{1'b0}}} + NW'(den_eff >> 1);
        rem  <= 32'd0;
      end else if (busy) begin
        rem <= qbit ? 32'(trial - {1'b0, d}) : trial[31:0];
        nq  <= {nq[NW-2:0], qbit};
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg) begin
      sat = (|nq[NW-1:32]) || (nq[31] && (|nq[30:0]));
    end else begin
      sat = |nq[NW-1:31];
    end
    if (sat) begin
      quo = neg ? LU_SAT_MIN : LU_SAT_MAX;
    end else begin
      quo = neg ? (~nq[31:0] + 32'd1) : nq[31:0];
    end
  end

endmodule

FILE: rtl/lu_linear_solver_unit.sv
// lu_linear_solver_unit: fixed-point lu decomposition with scaled partial pivoting,
// substitution for one right-hand side or a full inverse; uses lu_pkg and lu_div
// a compute runs the copy pass, the multiply-accumulates of the shared mac loop (also
//   for the inverse) and the divisions in lu_div, then emits its results in order
// throughput: one request at a time; a new request is taken once all results are out
// reset: rst synchronous active high; clears control state, pivot order, row scale,
//   parity, matrix_size to 8 and invert_mode to 0; the stores are undefined until written
module lu_linear_solver_unit import lu_pkg::*; #(
  parameter int MAX_ORDER     = LU_MAX_ORDER,
  parameter int FRACTION_BITS = LU_FRACTION_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  // request stream
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [LU_S_TDATA_W-1:0] s_tdata,   // row_index[2:0], col_index[5:3], entry_value[37:6]
  input  logic [LU_S_TUSER_W-1:0] s_tuser,   // command[1:0]
  // result stream
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [LU_M_TDATA_W-1:0] m_tdata,   // result_value[31:0], result_row[34:32], result_col[37:35]
  output logic [LU_M_TUSER_W-1:0] m_tuser,   // status[1:0], swap_parity[2]
  output logic                    m_tlast,   // last_result
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [LU_PADDR_W-1:0]   paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int IW    = $clog2(MAX_ORDER);
  localparam int CW    = $clog2(MAX_ORDER + 1);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int CNT_W = AW + 1;
  localparam int RW    = 64 - FRACTION_BITS;
  localparam int ACC_W = RW + IW + 2;
  localparam logic [31:0] ONE  = 32'(1) << FRACTION_BITS;
  localparam logic [63:0] HALF = 64'(1) << (FRACTION_BITS - 1);

  function automatic logic [IW-1:0] ix(input logic [CW-1:0] v);
    return v[IW-1:0];
  endfunction

  lu_state_t state, state_next;
  lu_phase_t phase;

  // configuration
  logic [3:0]    matrix_size;
  logic          invert_mode;
  logic [CW-1:0] n, n_m1;

  // memories: loaded matrix, working copy, result buffer
  logic [31:0]        mat_mem [DEPTH];
  logic [31:0]        mat_rd;
  logic [31:0]        work_mem [DEPTH];
  logic [31:0]        rd_a, rd_b;
  logic [31+AW:0]     res_mem [DEPTH];
  logic [31+AW:0]     res_rd;
  logic [AW-1:0]      addr_a, addr_b, w_addr;
  logic               w_we;
  logic [31:0]        w_data;

  // small register files
  logic [31:0]   rhs [MAX_ORDER];
  logic [31:0]   vec [MAX_ORDER];
  logic [31:0]   row_scale [MAX_ORDER];
  logic [IW-1:0] pivot_order [MAX_ORDER];
  logic          parity_flag;

  // loop counters
  logic [CW-1:0] i, j, k, khi, c;
  logic [IW-1:0] best, zr;

  // mac datapath
  logic signed [ACC_W-1:0] acc;
  logic [63:0]   prod;
  logic          pneg;
  logic [RW-1:0] rnd;
  logic          rneg;
  logic [31:0]   vb;
  logic [31:0]   acc_sat;
  logic          acc_ovf;
  logic [31:0]   mac_b;

  // pivot search
  logic [31:0] tm, bestmag, bestscale, hold, piv;
  logic [63:0] p1, p2;
  logic        par, sat_seen, zero_found;

  // copy pass
  logic [31:0] big, cp_mag, cp_big;
  logic        cp_row_end;

  // results
  logic [CNT_W-1:0] res_cnt, em;

  // divider
  logic        dv_start, dv_done, dv_sat;
  logic [31:0] dv_num, dv_den, dv_q;

  // request decode
  logic        in_acc;
  logic [1:0]  in_cmd;
  logic [2:0]  in_row, in_col;
  logic [31:0] in_val;
  logic        in_row_ok, in_col_ok;

  assign in_cmd    = s_tuser[1:0];
  assign in_row    = s_tdata[2:0];
  assign in_col    = s_tdata[5:3];
  assign in_val    = s_tdata[37:6];
  assign in_acc    = s_tvalid && s_tready;
  assign in_row_ok = (32'(in_row) < 32'(MAX_ORDER));
  assign in_col_ok = (32'(in_col) < 32'(MAX_ORDER));
  assign s_tready  = (state == ST_IDLE);

  // effective order: 0 acts as 1, above the maximum clamps
  always_comb begin
    if (matrix_size == 4'd0) begin
      n = CW'(1);
    end else if (32'(matrix_size) > 32'(MAX_ORDER)) begin
      n = CW'(MAX_ORDER);
    end else begin
      n = CW'(matrix_size);
    end
    n_m1 = n - CW'(1);
  end

  // saturation of the wide accumulator to 32 bits
  assign acc_ovf = !(&acc[ACC_W-1:31]) && (|acc[ACC_W-1:31]);
  assign acc_sat = acc_ovf ? (acc[ACC_W-1] ? LU_SAT_MIN : LU_SAT_MAX) : acc[31:0];

  // second mac operand: working matrix during lu, solution vector during substitution
  assign mac_b = (phase == PH_LU) ? rd_b : vb;

  assign cp_mag     = lu_mag(mat_rd);
  assign cp_big     = (k == CW'(0) || cp_mag > big) ? cp_mag : big;
  assign cp_row_end = (k == n_m1);

  // apb register file
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {31'd0, invert_mode} : {28'd0, matrix_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= 4'd8;
      invert_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_SIZE: matrix_size <= pwdata[3:0];
        REG_MODE: invert_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  // loaded matrix store, written by requests, read by the copy pass
  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == CMD_MATRIX && in_row_ok && in_col_ok) begin
      mat_mem[{IW'(in_row), IW'(in_col)}] <= in_val;
    end
    mat_rd <= mat_mem[{ix(i), ix(k)}];
  end

  // working matrix: two read ports, one write port
  always_ff @(posedge clk) begin
    if (w_we) begin
      work_mem[w_addr] <= w_data;
    end
    rd_a <= work_mem[addr_a];
    rd_b <= work_mem[addr_b];
  end

  // result buffer, filled column by column, drained in order
  always_ff @(posedge clk) begin
    if (state == ST_OUT_WR) begin
      res_mem[res_cnt[AW-1:0]] <= {vec[ix(i)], ix(i), ix(c)};
    end
    res_rd <= res_mem[em[AW-1:0]];
  end

  // working-matrix addressing per step
  always_comb begin
    addr_a = {ix(i), ix(k)};
    addr_b = {ix(k), ix(j)};
    w_we   = 1'b0;
    w_addr = {ix(i), ix(j)};
    w_data = acc_sat;
    case (state)
      ST_LU_ROW, ST_DV_RD: addr_a = {ix(i), ix(j)};
      ST_SW_RD: begin
        addr_a = {best, ix(k)};
        addr_b = {ix(j), ix(k)};
      end
      ST_PV_RD: addr_a = {ix(j), ix(j)};
      ST_BK_ST: addr_a = {ix(i), ix(i)};
      ST_CP_WR: begin
        w_we   = 1'b1;
        w_addr = {ix(i), ix(k)};
        w_data = mat_rd;
      end
      ST_LU_ST: w_we = 1'b1;
      ST_SW_W1: begin
        w_we   = 1'b1;
        w_addr = {best, ix(k)};
        w_data = rd_b;
      end
      ST_SW_W2: begin
        w_we   = 1'b1;
        w_addr = {ix(j), ix(k)};
        w_data = hold;
      end
      ST_PV_FIX: begin
        w_we   = (rd_a == 32'd0);
        w_addr = {ix(j), ix(j)};
        w_data = 32'd1;
      end
      ST_DV_WT: begin
        w_we   = dv_done;
        w_data = dv_q;
      end
      default: ;
    endcase
  end

  // shared divider: lu column scaling and back substitution
  assign dv_start = (state == ST_DV_GO) || (state == ST_BK_GO);
  assign dv_num   = (state == ST_DV_GO) ? rd_a : hold;
  assign dv_den   = (state == ST_DV_GO) ? piv : rd_a;

  lu_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(dv_start),
    .num  (dv_num),
    .den  (dv_den),
    .done (dv_done),
    .quo  (dv_q),
    .sat  (dv_sat)
  );

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && in_cmd == CMD_COMPUTE) state_next = ST_CP_RD;
      end
      ST_CP_RD: state_next = ST_CP_WR;
      ST_CP_WR: begin
        if (cp_row_end && i == n_m1) begin
          if (zero_found || cp_big == 32'd0) state_next = ST_EM_RD;
          else state_next = ST_LU_COL;
        end else begin
          state_next = ST_CP_RD;
        end
      end
      ST_LU_COL: state_next = (j == n) ? ST_SB_INIT : ST_LU_ROW;
      ST_LU_ROW: state_next = (i == n) ? ST_SW_CHK : ST_LU_LD;
      ST_LU_LD:  state_next = ST_DOT_RD;
      ST_DOT_RD: begin
        if (k == khi) begin
          case (phase)
            PH_LU:   state_next = ST_LU_ST;
            PH_FWD:  state_next = ST_FW_ST;
            PH_BACK: state_next = ST_BK_ST;
            default: state_next = ST_LU_ST;
          endcase
        end else begin
          state_next = ST_DOT_MUL;
        end
      end
      ST_DOT_MUL: state_next = ST_DOT_RND;
      ST_DOT_RND: state_next = ST_DOT_ACC;
      ST_DOT_ACC: state_next = ST_DOT_RD;
      ST_LU_ST:   state_next = (i < j) ? ST_LU_ROW : ST_PIV_M1;
      ST_PIV_M1:  state_next = ST_PIV_M2;
      ST_PIV_M2:  state_next = ST_PIV_CMP;
      ST_PIV_CMP: state_next = ST_LU_ROW;
      ST_SW_CHK:  state_next = (best != ix(j)) ? ST_SW_RD : ST_PV_RD;
      ST_SW_RD:   state_next = (k == n) ? ST_SW_SC : ST_SW_W1;
      ST_SW_W1:   state_next = ST_SW_W2;
      ST_SW_W2:   state_next = ST_SW_RD;
      ST_SW_SC:   state_next = ST_PV_RD;
      ST_PV_RD:   state_next = ST_PV_FIX;
      ST_PV_FIX:  state_next = ST_DV_RD;
      ST_DV_RD:   state_next = (i == n) ? ST_LU_COL : ST_DV_GO;
      ST_DV_GO:   state_next = ST_DV_WT;
      ST_DV_WT: begin
        if (dv_done) state_next = ST_DV_RD;
      end
      ST_SB_INIT: state_next = ST_FW_ROW;
      ST_FW_ROW:  state_next = (i == n) ? ST_BK_ROW : ST_FW_SW;
      ST_FW_SW:   state_next = ST_DOT_RD;
      ST_FW_ST:   state_next = ST_FW_ROW;
      ST_BK_ROW:  state_next = ST_DOT_RD;
      ST_BK_ST:   state_next = ST_BK_GO;
      ST_BK_GO:   state_next = ST_BK_WT;
      ST_BK_WT: begin
        if (dv_done) state_next = (i == CW'(0)) ? ST_OUT_WR : ST_BK_ROW;
      end
      ST_OUT_WR: begin
        if (i == n_m1) begin
          state_next = (invert_mode && c != n_m1) ? ST_SB_INIT : ST_EM_RD;
        end
      end
      ST_EM_RD:   state_next = ST_EM_SHOW;
      ST_EM_SHOW: state_next = ST_EM_WAIT;
      ST_EM_WAIT: begin
        if (m_tready) state_next = (em == res_cnt - CNT_W'(1)) ? ST_IDLE : ST_EM_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and bookkeeping per step
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      parity_flag <= 1'b0;
      for (int r = 0; r < MAX_ORDER; r++) begin
        row_scale[r]   <= 32'd0;
        pivot_order[r] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc && in_cmd == CMD_RHS && in_row_ok) begin
            rhs[IW'(in_row)] <= in_val;
          end
          i          <= '0;
          j          <= '0;
          k          <= '0;
          c          <= '0;
          par        <= 1'b0;
          sat_seen   <= 1'b0;
          zero_found <= 1'b0;
          res_cnt    <= '0;
          em         <= '0;
        end
        ST_CP_WR: begin
          big <= cp_big;
          if (cp_row_end) begin
            row_scale[ix(i)] <= cp_big;
            if (cp_big == 32'd0 && !zero_found) begin
              zero_found <= 1'b1;
              zr         <= ix(i);
              res_cnt    <= CNT_W'(1);
            end
            k <= '0;
            i <= i + CW'(1);
          end else begin
            k <= k + CW'(1);
          end
        end
        ST_LU_COL: begin
          i    <= '0;
          best <= ix(j);
          if (j == n) parity_flag <= par;
        end
        ST_LU_LD: begin
          acc   <= ACC_W'($signed(rd_a));
          k     <= '0;
          khi   <= (i < j) ? i : j;
          phase <= PH_LU;
        end
        ST_DOT_RD: vb <= vec[ix(k)];
        ST_DOT_MUL: begin
          prod <= 64'(lu_mag(rd_a)) * 64'(lu_mag(mac_b));
          pneg <= rd_a[31] ^ mac_b[31];
        end
        ST_DOT_RND: begin
          rnd  <= RW'((prod + HALF) >> FRACTION_BITS);
          rneg <= pneg;
        end
        ST_DOT_ACC: begin
          acc <= rneg ? acc + ACC_W'(rnd) : acc - ACC_W'(rnd);
          k   <= k + CW'(1);
        end
        ST_LU_ST: begin
          sat_seen <= sat_seen | acc_ovf;
          tm       <= lu_mag(acc_sat);
          if (i < j) i <= i + CW'(1);
        end
        ST_PIV_M1: p1 <= 64'(tm) * 64'(bestscale);
        ST_PIV_M2: p2 <= 64'(bestmag) * 64'(row_scale[ix(i)]);
        ST_PIV_CMP: begin
          // later row wins a tie; the diagonal row always seeds the search
          if (i == j || p1 >= p2) begin
            best      <= ix(i);
            bestmag   <= tm;
            bestscale <= row_scale[ix(i)];
          end
          i <= i + CW'(1);
        end
        ST_SW_CHK: k <= '0;
        ST_SW_W1:  hold <= rd_a;
        ST_SW_W2:  k <= k + CW'(1);
        ST_SW_SC: begin
          row_scale[best]  <= row_scale[ix(j)];
          row_scale[ix(j)] <= bestscale;
          par              <= ~par;
        end
        ST_PV_RD: pivot_order[ix(j)] <= best;
        ST_PV_FIX: begin
          // zero pivot becomes one lsb
          piv <= (rd_a == 32'd0) ? 32'd1 : rd_a;
          i   <= j + CW'(1);
        end
        ST_DV_RD: begin
          if (i == n) j <= j + CW'(1);
        end
        ST_DV_WT: begin
          if (dv_done) begin
            sat_seen <= sat_seen | dv_sat;
            i        <= i + CW'(1);
          end
        end
        ST_SB_INIT: begin
          i <= '0;
          for (int r = 0; r < MAX_ORDER; r++) begin
            if (invert_mode) begin
              vec[r] <= (CW'(r) == c) ? ONE : 32'd0;
            end else begin
              vec[r] <= rhs[r];
            end
          end
        end
        ST_FW_ROW: begin
          if (i == n) begin
            i <= n_m1;
          end else begin
            hold <= vec[pivot_order[ix(i)]];
          end
        end
        ST_FW_SW: begin
          vec[pivot_order[ix(i)]] <= vec[ix(i)];
          acc   <= ACC_W'($signed(hold));
          k     <= '0;
          khi   <= i;
          phase <= PH_FWD;
        end
        ST_FW_ST: begin
          vec[ix(i)] <= acc_sat;
          sat_seen   <= sat_seen | acc_ovf;
          i          <= i + CW'(1);
        end
        ST_BK_ROW: begin
          acc   <= ACC_W'($signed(vec[ix(i)]));
          k     <= i + CW'(1);
          khi   <= n;
          phase <= PH_BACK;
        end
        ST_BK_ST: begin
          hold     <= acc_sat;
          sat_seen <= sat_seen | acc_ovf;
        end
        ST_BK_WT: begin
          if (dv_done) begin
            vec[ix(i)] <= dv_q;
            sat_seen   <= sat_seen | dv_sat;
            if (i != CW'(0)) i <= i - CW'(1);
          end
        end
        ST_OUT_WR: begin
          res_cnt <= res_cnt + CNT_W'(1);
          i       <= i + CW'(1);
          if (i == n_m1 && invert_mode && c != n_m1) c <= c + CW'(1);
        end
        ST_EM_SHOW: begin
          m_tvalid <= 1'b1;
          if (zero_found) begin
            // singular run: a single result naming the first zero row
            m_tdata <= {2'd0, 3'd0, 3'(zr), 32'd0};
            m_tuser <= {1'b0, STAT_SINGULAR};
            m_tlast <= 1'b1;
          end else begin
            m_tdata <= {2'd0, 3'(res_rd[IW-1:0]), 3'(res_rd[AW-1:IW]), res_rd[31+AW:AW]};
            m_tuser <= {parity_flag, sat_seen ? STAT_SAT : STAT_OK};
            m_tlast <= (em == res_cnt - CNT_W'(1));
          end
        end
        ST_EM_WAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            em       <= em + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/lu_chk.sv
// lu_chk: port-level checks of the lu solver result stream and register port
// depends on lu_pkg; bound to lu_linear_solver_unit
module lu_chk import lu_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    s_tready,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [LU_M_TDATA_W-1:0] m_tdata,
  input logic [LU_M_TUSER_W-1:0] m_tuser,
  input logic                    m_tlast,
  input logic                    pready
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("result changed while stalled");

  // no new request while results are pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("request taken while results pending");

  // run ends after its last result
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
    else $error("activity after last result");

  // reset leaves the block idle and ready
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

  a_rdy: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind lu_linear_solver_unit lu_chk u_lu_chk (.*);

FILE: test/tb.sv
// tb: self-checking testbench for lu_linear_solver_unit (loads, solve and invert runs)
// depends on lu_pkg and the solver rtl; predicts every result in-line and compares per field
`timescale 1ns / 100ps

module tb;
  import lu_pkg::*;

  localparam int NMAX = LU_MAX_ORDER;
  localparam int FB   = LU_FRACTION_BITS;
  localparam longint CYCLE_LIMIT = 64'd2_000_000;

  // command with no effect, register addresses
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [LU_PADDR_W-1:0] ADDR_SIZE = {REG_SIZE, 2'b00};
  localparam logic [LU_PADDR_W-1:0] ADDR_MODE = {REG_MODE, 2'b00};

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [1:0]  status;
    logic        parity;
    logic        last;
  } lu_result_t;

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [LU_S_TDATA_W-1:0] s_tdata;
  logic [LU_S_TUSER_W-1:0] s_tuser;
  logic m_tvalid, m_tready;
  logic [LU_M_TDATA_W-1:0] m_tdata;
  logic [LU_M_TUSER_W-1:0] m_tuser;
  logic m_tlast;
  logic psel, penable, pwrite, pready;
  logic [LU_PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  lu_linear_solver_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic signed [31:0] mat_copy [NMAX*NMAX];
  logic signed [31:0] rhs_copy [NMAX];
  int                 order_cfg;
  bit                 inverse_cfg;
  longint             lu_work [NMAX][NMAX];
  longint             sub_vec [NMAX];
  int                 piv_row [NMAX];
  bit                 swap_par;
  bit                 sat_hit;

  lu_result_t expected_results [$];
  int  errors;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // global cycle guard
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------- fixed point helpers ----------------
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) begin sat_hit = 1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin sat_hit = 1; return -64'sd2147483648; end
    return v;
  endfunction

  function automatic longint unsigned absval(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // exact product rounded half away from zero
  function automatic longint qmul(longint a, longint b);
    bit neg;
    longint unsigned p, r;
    neg = (a < 0) != (b < 0);
    p = absval(a) * absval(b);
    r = (p + (64'd1 << (FB - 1))) >> FB;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // rounded quotient, zero divisor acts as one lsb
  function automatic longint qdiv(longint num, longint den);
    bit neg;
    longint unsigned d, q;
    neg = (num < 0) != (den < 0);
    d = absval(den);
    if (d == 0) begin d = 1; neg = num < 0; end
    q = ((absval(num) << FB) + d / 2) / d;
    return clamp32(neg ? -longint'(q) : longint'(q));
  endfunction

  task automatic substitute_vec(int n);
    int i, j, ip;
    longint s;
    for (i = 0; i < n; i++) begin
      ip = piv_row[i];
      s = sub_vec[ip];
      sub_vec[ip] = sub_vec[i];
      for (j = 0; j < i; j++) s -= qmul(lu_work[i][j], sub_vec[j]);
      sub_vec[i] = clamp32(s);
    end
    for (i = n - 1; i >= 0; i--) begin
      s = sub_vec[i];
      for (j = i + 1; j < n; j++) s -= qmul(lu_work[i][j], sub_vec[j]);
      sub_vec[i] = qdiv(clamp32(s), lu_work[i][i]);
    end
  endtask

  // crout decomposition with scaled pivoting; returns first zero row or -1
  function automatic int factor_matrix(int n);
    longint unsigned scale [NMAX];
    longint unsigned bestmag, m, big, ts;
    longint s, tmp;
    int i, j, k, best, zrow;
    bit par;
    zrow = -1;
    par = 0;
    for (i = 0; i < n; i++) begin
      big = 0;
      for (j = 0; j < n; j++) begin
        m = absval(lu_work[i][j]);
        if (m > big) big = m;
      end
      scale[i] = big;
      if (big == 0 && zrow < 0) zrow = i;
    end
    if (zrow >= 0) return zrow;
    for (j = 0; j < n; j++) begin
      for (i = 0; i < j; i++) begin
        s = lu_work[i][j];
        for (k = 0; k < i; k++) s -= qmul(lu_work[i][k], lu_work[k][j]);
        lu_work[i][j] = clamp32(s);
      end
      best = j;
      bestmag = 0;
      for (i = j; i < n; i++) begin
        s = lu_work[i][j];
        for (k = 0; k < j; k++) s -= qmul(lu_work[i][k], lu_work[k][j]);
        lu_work[i][j] = clamp32(s);
        m = absval(lu_work[i][j]);
        if (i == j || m * scale[best] >= bestmag * scale[i]) begin
          best = i;
          bestmag = m;
        end
      end
      if (best != j) begin
        for (k = 0; k < n; k++) begin
          tmp = lu_work[best][k];
          lu_work[best][k] = lu_work[j][k];
          lu_work[j][k] = tmp;
        end
        par ^= 1'b1;
        ts = scale[best];
        scale[best] = scale[j];
        scale[j] = ts;
      end
      piv_row[j] = best;
      if (lu_work[j][j] == 0) lu_work[j][j] = 1;
      for (i = j + 1; i < n; i++) lu_work[i][j] = qdiv(lu_work[i][j], lu_work[j][j]);
    end
    swap_par = par;
    return -1;
  endfunction

  // predict the results of one request and queue them
  task automatic predict_request(logic [1:0] cmd, int r, int c, logic [31:0] v);
    int n, i, j, zr, total, cnt;
    longint inv_res [NMAX][NMAX];
    lu_result_t e;
    logic [1:0] st;
    if (cmd == CMD_MATRIX) begin
      mat_copy[r*NMAX + c] = v;
      return;
    end
    if (cmd == CMD_RHS) begin
      rhs_copy[r] = v;
      return;
    end
    if (cmd != CMD_COMPUTE) return;
    n = order_cfg < 1 ? 1 : (order_cfg > NMAX ? NMAX : order_cfg);
    sat_hit = 0;
    for (i = 0; i < n; i++)
      for (j = 0; j < n; j++) lu_work[i][j] = mat_copy[i*NMAX + j];
    zr = factor_matrix(n);
    if (zr >= 0) begin
      e = '{value: 32'd0, row: zr[2:0], col: 3'd0, status: STAT_SINGULAR,
            parity: 1'b0, last: 1'b1};
      expected_results.push_back(e);
      return;
    end
    if (inverse_cfg) begin
      for (c = 0; c < n; c++) begin
        for (i = 0; i < n; i++) sub_vec[i] = 0;
        sub_vec[c] = 64'sd1 <<< FB;
        substitute_vec(n);
        for (i = 0; i < n; i++) inv_res[i][c] = sub_vec[i];
      end
      st = sat_hit ? STAT_SAT : STAT_OK;
      total = n * n;
      cnt = 0;
      for (c = 0; c < n; c++)
        for (i = 0; i < n; i++) begin
          e = '{value: inv_res[i][c][31:0], row: i[2:0], col: c[2:0], status: st,
                parity: swap_par, last: (cnt == total - 1)};
          expected_results.push_back(e);
          cnt++;
        end
      return;
    end
    for (i = 0; i < n; i++) sub_vec[i] = rhs_copy[i];
    substitute_vec(n);
    st = sat_hit ? STAT_SAT : STAT_OK;
    for (i = 0; i < n; i++) begin
      e = '{value: sub_vec[i][31:0], row: i[2:0], col: 3'd0, status: st,
            parity: swap_par, last: (i == n - 1)};
      expected_results.push_back(e);
    end
  endtask

  // ---------------- result side: random stall, compare ----------------
  initial begin
    lu_result_t got, exp_r;
    int stall;
    m_tready = 1'b0;
    errors = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got = '{value: m_tdata[31:0], row: m_tdata[34:32], col: m_tdata[37:35],
                status: m_tuser[1:0], parity: m_tuser[2], last: m_tlast};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.value !== exp_r.value)
            $display("%0t: value expected %h actual %h", $time, exp_r.value, got.value);
          if (got.row !== exp_r.row)
            $display("%0t: row expected %0d actual %0d", $time, exp_r.row, got.row);
          if (got.col !== exp_r.col)
            $display("%0t: col expected %0d actual %0d", $time, exp_r.col, got.col);
          if (got.status !== exp_r.status)
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
          if (got.parity !== exp_r.parity)
            $display("%0t: parity expected %0d actual %0d", $time, exp_r.parity, got.parity);
          if (got.last !== exp_r.last)
            $display("%0t: last expected %0d actual %0d", $time, exp_r.last, got.last);
          if (got !== exp_r) errors++;
        end
      end
      // mostly ready, otherwise short stalls and a few long ones
      stall = $urandom_range(0, 99);
      if (stall < 55) m_tready <= 1'b1;
      else if (stall < 95) m_tready <= 1'b0;
      else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(5, 30)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------- request side ----------------
  task automatic reg_write(logic [LU_PADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    if (addr[2] == REG_SIZE) order_cfg = int'(data[3:0]);
    else inverse_cfg = data[0];
  endtask

  // wait until every result is back plus a tail for commands with no result
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // valid stays up after a load so the next request can follow at once;
  // every caller either sends again or drains in the same step
  task automatic send_request(logic [1:0] cmd, logic [2:0] r, logic [2:0] c,
                              logic [31:0] v, bit typed = 1'b0,
                              lu_result_t typed_res = '0);
    int gap;
    gap = $urandom_range(0, 99);
    if (gap >= 60) begin
      s_tvalid <= 1'b0;
      repeat (gap < 95 ? $urandom_range(1, 3) : $urandom_range(8, 40)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {2'b00, v, c, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (typed) expected_results.push_back(typed_res);
    else predict_request(cmd, r, c, v);
    // compute waits for its run to finish so results stay paired with requests
    if (cmd == CMD_COMPUTE) begin
      s_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clk);
    end
  endtask

  // load a full matrix and rhs of order n with random content
  task automatic load_system(int n, int mode);
    int i, j;
    logic [31:0] v;
    for (i = 0; i < n; i++) begin
      for (j = 0; j < n; j++) begin
        case (mode)
          0: v = $urandom_range(0, 3) == 0 ? 32'd0 : ($urandom() >>> 12) - 32'h0008_0000;
          1: v = (i == j) ? 32'h0001_0000 * $urandom_range(1, 4) :
                 $urandom_range(0, 32'h1_0000) - 32'h8000;
          default: v = $urandom();
        endcase
        send_request(CMD_MATRIX, i[2:0], j[2:0], v);
      end
      v = mode == 2 ? $urandom() : ($urandom() >>> 10) - 32'h0020_0000;
      send_request(CMD_RHS, i[2:0], 3'd0, v);
    end
  endtask

  typedef struct {
    logic [1:0]  cmd;
    logic [2:0]  r;
    logic [2:0]  c;
    logic [31:0] v;
    bit          typed;
    lu_result_t  res;
  } stim_row_t;

  initial begin
    stim_row_t directed [$];
    int k, n, step;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    order_cfg = 8; inverse_cfg = 0; swap_par = 0;
    for (k = 0; k < NMAX*NMAX; k++) mat_copy[k] = 0;
    for (k = 0; k < NMAX; k++) begin rhs_copy[k] = 0; piv_row[k] = 0; end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: order 2, zero row, pivot swap, extremes, unused command
    reg_write(ADDR_SIZE, 32'd2);
    directed = '{
      '{CMD_MATRIX, 3'd0, 3'd0, 32'h0001_0000, 1'b0, '0},
      '{CMD_MATRIX, 3'd0, 3'd1, 32'h0000_0000, 1'b0, '0},
      '{CMD_MATRIX, 3'd1, 3'd0, 32'h0000_0000, 1'b0, '0},
      '{CMD_MATRIX, 3'd1, 3'd1, 32'h0000_0000, 1'b0, '0},
      '{CMD_RHS,    3'd0, 3'd0, 32'h0002_0000, 1'b0, '0},
      '{CMD_RHS,    3'd1, 3'd7, 32'h0003_0000, 1'b0, '0},
      // singular: zero row 1, a single status result
      '{CMD_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b1,
        '{value: 32'd0, row: 3'd1, col: 3'd0, status: STAT_SINGULAR,
          parity: 1'b0, last: 1'b1}},
      '{CMD_UNUSED, 3'd7, 3'd7, 32'hffff_ffff, 1'b0, '0},
      '{CMD_MATRIX, 3'd0, 3'd0, 32'h0000_0000, 1'b0, '0},
      '{CMD_MATRIX, 3'd0, 3'd1, 32'h0001_0000, 1'b0, '0},
      '{CMD_MATRIX, 3'd1, 3'd0, 32'h0001_0000, 1'b0, '0},
      '{CMD_MATRIX, 3'd1, 3'd1, 32'h0000_0000, 1'b0, '0},
      // swap needed, parity odd
      '{CMD_COMPUTE, 3'd7, 3'd7, 32'hffff_ffff, 1'b0, '0},
      '{CMD_MATRIX, 3'd0, 3'd0, 32'h7fff_ffff, 1'b0, '0},
      '{CMD_MATRIX, 3'd1, 3'd1, 32'h8000_0000, 1'b0, '0},
      '{CMD_MATRIX, 3'd0, 3'd1, 32'h0000_0001, 1'b0, '0},
      '{CMD_MATRIX, 3'd1, 3'd0, 32'h0000_0001, 1'b0, '0},
      '{CMD_RHS,    3'd0, 3'd0, 32'h7fff_ffff, 1'b0, '0},
      '{CMD_RHS,    3'd1, 3'd0, 32'h8000_0000, 1'b0, '0},
      // extremes, saturation likely
      '{CMD_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b0, '0},
      '{CMD_MATRIX, 3'd0, 3'd0, 32'h0000_0001, 1'b0, '0},
      '{CMD_MATRIX, 3'd1, 3'd1, 32'h0000_0000, 1'b0, '0},
      // tie in the pivot search, the later row is taken
      '{CMD_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b0, '0}
    };
    foreach (directed[i]) begin
      send_request(directed[i].cmd, directed[i].r, directed[i].c, directed[i].v,
                   directed[i].typed, directed[i].res);
    end
    drain_results();
    reg_write(ADDR_MODE, 32'd1);
    send_request(CMD_COMPUTE, 3'd0, 3'd0, 32'h0);
    drain_results();

    // random phases: random systems of three kinds, random sizes and modes, some noise
    for (step = 0; step < 9; step++) begin
      n = (step % 4 == 3) ? 8 : $urandom_range(1, 4);
      if (step == 2) n = 0;
      if (step == 5) n = 15;
      drain_results();
      reg_write(ADDR_SIZE, n);
      reg_write(ADDR_MODE, $urandom_range(0, 1));
      n = order_cfg < 1 ? 1 : (order_cfg > NMAX ? NMAX : order_cfg);
      load_system(n, step % 3);
      send_request(CMD_COMPUTE, 3'($urandom()), 3'($urandom()), $urandom());
      // a few single-entry updates followed by recompute
      for (k = 0; k < 6; k++) begin
        if ($urandom_range(0, 5) == 0)
          send_request(CMD_UNUSED, 3'($urandom()), 3'($urandom()), $urandom());
        send_request(CMD_MATRIX, 3'($urandom_range(0, n - 1)), 3'($urandom_range(0, n - 1)),
                     $urandom_range(0, 1) ? $urandom() : ($urandom() >>> 14) - 32'h2_0000);
        if ($urandom_range(0, 1))
          send_request(CMD_RHS, 3'($urandom_range(0, n - 1)), 3'($urandom()), $urandom());
        if (k % 2 == 1)
          send_request(CMD_COMPUTE, 3'($urandom()), 3'($urandom()), $urandom());
      end
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lu_pkg.sv
rtl/lu_div.sv
rtl/lu_linear_solver_unit.sv
rtl/lu_chk.sv
test/tb.sv
